FILE: rtl/hsv_pkg.sv
`timescale 1ns / 1ps

package hsv_pkg;

	localparam int HUE_W   = 13;
	localparam int CH_W    = 8;
	localparam int FRAC_W  = 10;
	localparam int PIX_W   = 16;
	localparam int IN_TDATA_W = 32;

	localparam logic [HUE_W-1:0]  HUE_FULL   = 13'd5760;
	localparam logic [FRAC_W-1:0] HUE_SECTOR = 10'd960;
	localparam logic [CH_W-1:0]   UNIT       = 8'd255;
	// 255 * 960
	localparam logic [17:0]       QT_DEN     = 18'd244800;
	// ceil(2^32 / 3825): x / 244800 == ((x >> 6) * RECIP) >> 32 for x < 2^26
	localparam logic [20:0]       RECIP      = 21'd1122868;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

endpackage

FILE: rtl/hsv_to_rgb565.sv
`timescale 1ns / 1ps
// channel | dir | width | contents (lsb first)
// s_*     | in  | 32    | hue[12:0], saturation[20:13], brightness[28:21], zero[31:29]
// m_*     | out | 16    | pixel[15:0] (RGB565)
//
// Six register stages, one request per cycle while m_tready does not stall the output.
// Depth is set by the q/t path: f*s, scale by v, reciprocal multiply for /244800.
// arst_n clears the stage valid bits only.
// A stall at m_tready freezes every stage; s_tready follows that freeze.
module hsv_to_rgb565
	import hsv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // hue, saturation, brightness
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata   // pixel
);

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [HUE_W-1:0]  hue_s1;
	logic [CH_W-1:0]   sat_s1, v_s1;

	sector_t           sec_s2, sec_s3, sec_s4, sec_s5;
	logic [FRAC_W-1:0] f_s2;
	logic [CH_W-1:0]   sat_s2, v_s2, v_s3, v_s4, v_s5;

	logic [17:0]       fs_s3, gs_s3;
	logic [15:0]       pn_s3;

	logic [25:0]       qn_s4, tn_s4;
	logic [CH_W-1:0]   p_s4, p_s5;

	logic [CH_W-1:0]   q_s5, t_s5;
	logic [PIX_W-1:0]  pix_s6;

	assign adv      = !vld_s6 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s6;
	assign m_tdata  = pix_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// s1: wrap hue into one turn
	logic [HUE_W-1:0] hue_in;
	assign hue_in = s_tdata[HUE_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s1 <= (hue_in >= HUE_FULL) ? hue_in - HUE_FULL : hue_in;
			sat_s1 <= s_tdata[HUE_W +: CH_W];
			v_s1   <= s_tdata[HUE_W+CH_W +: CH_W];
		end
	end

	// s2: sector and fraction
	sector_t          sec_c;
	logic [HUE_W-1:0] base_c;
	logic [HUE_W-1:0] frac_c;

	always_comb begin
		if (hue_s1 >= 13'd4800) begin
			sec_c = SEC_5; base_c = 13'd4800;
		end else if (hue_s1 >= 13'd3840) begin
			sec_c = SEC_4; base_c = 13'd3840;
		end else if (hue_s1 >= 13'd2880) begin
			sec_c = SEC_3; base_c = 13'd2880;
		end else if (hue_s1 >= 13'd1920) begin
			sec_c = SEC_2; base_c = 13'd1920;
		end else if (hue_s1 >= 13'd960) begin
			sec_c = SEC_1; base_c = 13'd960;
		end else begin
			sec_c = SEC_0; base_c = 13'd0;
		end
		frac_c = hue_s1 - base_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s2 <= sec_c;
			f_s2   <= frac_c[FRAC_W-1:0];
			sat_s2 <= sat_s1;
			v_s2   <= v_s1;
		end
	end

	// s3: f*s, (960-f)*s, v*(255-s)
	logic [FRAC_W-1:0] fc_c;
	assign fc_c = HUE_SECTOR - f_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			fs_s3  <= 18'(f_s2 * sat_s2);
			gs_s3  <= 18'(fc_c * sat_s2);
			pn_s3  <= 16'(v_s2 * (UNIT - sat_s2));
			sec_s3 <= sec_s2;
			v_s3   <= v_s2;
		end
	end

	// s4: scale q/t by v, p = pn / 255
	logic [17:0] qa_c, ta_c;
	logic [15:0] pn1_c, psum_c;

	assign qa_c   = QT_DEN - fs_s3;
	assign ta_c   = QT_DEN - gs_s3;
	assign pn1_c  = pn_s3 + 16'd1;
	assign psum_c = pn1_c + {8'd0, pn1_c[15:8]};

	always_ff @(posedge clk) begin
		if (adv) begin
			qn_s4  <= 26'(qa_c * v_s3);
			tn_s4  <= 26'(ta_c * v_s3);
			p_s4   <= psum_c[15:8];
			sec_s4 <= sec_s3;
			v_s4   <= v_s3;
		end
	end

	// s5: divide by 255*960 via reciprocal
	logic [40:0] qm_c, tm_c;

	assign qm_c = qn_s4[25:6] * RECIP;
	assign tm_c = tn_s4[25:6] * RECIP;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s5   <= qm_c[39:32];
			t_s5   <= tm_c[39:32];
			p_s5   <= p_s4;
			sec_s5 <= sec_s4;
			v_s5   <= v_s4;
		end
	end

	// s6: channel order and pack
	logic [CH_W-1:0] r_c, g_c, b_c;

	always_comb begin
		case (sec_s5)
			SEC_0: begin r_c = v_s5; g_c = t_s5; b_c = p_s5; end
			SEC_1: begin r_c = q_s5; g_c = v_s5; b_c = p_s5; end
			SEC_2: begin r_c = p_s5; g_c = v_s5; b_c = t_s5; end
			SEC_3: begin r_c = p_s5; g_c = q_s5; b_c = v_s5; end
			SEC_4: begin r_c = t_s5; g_c = p_s5; b_c = v_s5; end
			default: begin r_c = v_s5; g_c = p_s5; b_c = q_s5; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s6 <= {r_c[7:3], g_c[7:2], b_c[7:3]};
		end
	end

endmodule

FILE: dv/hsv_to_rgb565_test.sv
`timescale 1ns / 1ps

module hsv_to_rgb565_test;
	import hsv_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int RESET_CYC  = 5;
	localparam int RAND_PER   = 583;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN_CYC  = 20;
	localparam int CYCLE_CAP  = 200000;

	class pixel_scoreboard;
		logic [PIX_W-1:0] expected_q[$];
		int mismatches;
		int checked;
		int wrapped;

		function logic [PIX_W-1:0] rgb565_of(logic [HUE_W-1:0] hue,
				logic [CH_W-1:0] sat, logic [CH_W-1:0] val);
			int unsigned full_v, sector_v, unit_v, den, h, s, v, f, p, q, t;
			sector_t sec;
			logic [CH_W-1:0] v8, p8, q8, t8;
			logic [CH_W-1:0] r, g, b;
			full_v   = 32'(HUE_FULL);
			sector_v = 32'(HUE_SECTOR);
			unit_v   = 32'(UNIT);
			den      = 32'(QT_DEN);
			h = 32'(hue);
			s = 32'(sat);
			v = 32'(val);
			if (h >= full_v) begin
				h = h - full_v;
			end
			sec = sector_t'(3'(h / sector_v));
			f   = h % sector_v;
			p = (v * (unit_v - s)) / unit_v;
			q = (v * (den - f * s)) / den;
			t = (v * (den - (sector_v - f) * s)) / den;
			v8 = val;
			p8 = CH_W'(p);
			q8 = CH_W'(q);
			t8 = CH_W'(t);
			case (sec)
				SEC_0: begin r = v8; g = t8; b = p8; end
				SEC_1: begin r = q8; g = v8; b = p8; end
				SEC_2: begin r = p8; g = v8; b = t8; end
				SEC_3: begin r = p8; g = q8; b = v8; end
				SEC_4: begin r = t8; g = p8; b = v8; end
				default: begin r = v8; g = p8; b = q8; end
			endcase
			return {r[7:3], g[7:2], b[7:3]};
		endfunction

		function void note_request(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
				logic [CH_W-1:0] val);
			if (hue >= HUE_FULL) begin
				wrapped++;
			end
			expected_q.push_back(rgb565_of(hue, sat, val));
		endfunction

		function void check_pixel(logic [PIX_W-1:0] got);
			logic [PIX_W-1:0] want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected pixel %h with nothing pending", got);
				end
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("pixel mismatch #%0d: expected %h got %h", checked, want, got);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;  // hue, saturation, brightness, zero pad
	logic                  m_tvalid;
	logic                  m_tready;
	logic [PIX_W-1:0]      m_tdata;  // pixel

	pixel_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int phase;
	int cycles;
	int sent;

	hsv_to_rgb565 u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAIL hsv_to_rgb565");
			$finish;
		end
	end

	// pixel sink
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_pixel(m_tdata);
		end
	end

	// backpressure, with one long hold-off as the last phase opens
	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (phase == 2 && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				for (int n = 0; n < LONG_HOLD; n++) begin
					@(negedge clk);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_request(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
			input logic [CH_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, val, sat, hue};
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.note_request(hue, sat, val);
		sent++;
	endtask

	task automatic run_random(input int count);
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat, val;
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 80) begin
				hue = HUE_W'($urandom_range(5759));
			end else if (roll < 92) begin
				// near a sector edge
				hue = HUE_W'($urandom_range(5) * 960 + $urandom_range(3) - 2 + 960 * (roll % 2));
				if (hue > 13'd5759) begin
					hue = HUE_W'($urandom_range(5759));
				end
			end else begin
				hue = HUE_W'($urandom_range(8191, 5760));
			end
			sat = CH_W'($urandom_range(255));
			val = CH_W'($urandom_range(255));
			roll = $urandom_range(99);
			if (roll < 5) begin
				sat = 8'd0;
			end else if (roll < 10) begin
				sat = 8'd255;
			end
			roll = $urandom_range(99);
			if (roll < 5) begin
				val = 8'd0;
			end else if (roll < 10) begin
				val = 8'd255;
			end
			send_request(hue, sat, val);
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		sent = 0;
		phase = 0;
		send_idle_pct = 21;
		recv_idle_pct = 77;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;

		// corners: range ends, wrap, sector edges, grey and black
		send_request(13'd0,    8'd255, 8'd255);
		send_request(13'd5759, 8'd255, 8'd255);
		send_request(13'd5760, 8'd255, 8'd255);
		send_request(13'd8191, 8'd255, 8'd255);
		send_request(13'd959,  8'd255, 8'd255);
		send_request(13'd960,  8'd200, 8'd255);
		send_request(13'd1919, 8'd255, 8'd200);
		send_request(13'd1920, 8'd255, 8'd255);
		send_request(13'd2880, 8'd170, 8'd255);
		send_request(13'd3840, 8'd255, 8'd128);
		send_request(13'd4799, 8'd255, 8'd255);
		send_request(13'd4800, 8'd255, 8'd255);
		send_request(13'd1000, 8'd0,   8'd200);
		send_request(13'd3000, 8'd128, 8'd0);
		send_request(13'd0,    8'd0,   8'd0);
		send_request(13'd2500, 8'd255, 8'd1);
		send_request(13'd7000, 8'd1,   8'd254);
		send_request(13'd480,  8'd170, 8'd85);
		send_request(13'd5000, 8'd85,  8'd170);
		send_request(13'd6719, 8'd255, 8'd255);
		run_random(RAND_PER);

		phase = 1;
		send_idle_pct = 77;
		recv_idle_pct = 21;
		run_random(RAND_PER);

		phase = 2;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(RAND_PER);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYC) @(posedge clk);

		$display("%0d requests (%0d with hue past 360 deg), %0d pixels checked, %0d mismatches",
			sent, sb.wrapped, sb.checked, sb.mismatches);
		$display("idle mixes: sender-light, receiver-light, none; one %0d-cycle output stall",
			LONG_HOLD);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("PASS hsv_to_rgb565");
		end else begin
			$display("FAIL hsv_to_rgb565");
		end
		$finish;
	end

endmodule

FILE: hsv_to_rgb565.f
rtl/hsv_pkg.sv
rtl/hsv_to_rgb565.sv
dv/hsv_to_rgb565_test.sv
